// ===== src/assert_macros.svh =====
// Assertion macros used by the checker of the point rotator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define PAX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PAX_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pax_pkg.sv =====
// Shared constants, types and the quarter-wave sine table of the point rotator.
package pax_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int PROD_W         = COORD_WIDTH + TRIG_W;
  localparam int DATA_W         = 3 * COORD_WIDTH;
  localparam int TDATA_W        = ((DATA_W + 7) / 8) * 8;

  localparam int ANGLE_W        = 17;
  localparam int STEPS_PER_DEG  = 128;
  localparam int DEG_BITS       = 7;
  localparam int QUARTER_STEPS  = 90 * STEPS_PER_DEG;
  localparam int FULL_STEPS     = 4 * QUARTER_STEPS;
  localparam int NORM_W         = 16;
  localparam int REM_W          = 14;
  localparam int TBL_IDX_W      = 7;
  localparam int TBL_LAST       = 90;
  localparam int SIN_W          = 17;

  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  // Register index as decoded from paddr[2]
  localparam logic REG_AXIS  = 1'b0;
  localparam logic REG_ANGLE = 1'b1;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1 << TRIG_FRAC_BITS);

  typedef enum logic [1:0] {
    AXIS_Z    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_X    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cosine;
    logic signed [TRIG_W-1:0] sine;
  } trig_t;

  // sin(k deg), k = 0..90, Q1.16
  localparam int SIN_TBL [TBL_LAST+1] = '{
    0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
    11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
    22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31772,
    32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
    42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
    50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
    56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
    61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
    64540, 64729, 64898, 65048, 65177, 65287, 65376, 65446, 65496, 65526,
    65536
  };

endpackage

// ===== src/pax_trig.sv =====
// Sine/cosine generator: runs a short sequence after each angle write.
module pax_trig (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [pax_pkg::ANGLE_W-1:0]  load_angle,
  output pax_pkg::trig_t                      trig,
  output logic                                busy
);

  localparam int EXT_W  = pax_pkg::TRIG_W + 18;
  localparam int UP_SH  = (pax_pkg::TRIG_FRAC_BITS >= 16) ? pax_pkg::TRIG_FRAC_BITS - 16 : 0;
  localparam int DN_SH  = (pax_pkg::TRIG_FRAC_BITS < 16) ? 16 - pax_pkg::TRIG_FRAC_BITS : 1;
  localparam int MUL_W  = pax_pkg::SIN_W + pax_pkg::DEG_BITS;

  localparam logic signed [17:0] FULL_S   = 18'(pax_pkg::FULL_STEPS);
  localparam logic signed [17:0] FULL2_S  = 18'(2 * pax_pkg::FULL_STEPS);
  localparam logic [pax_pkg::NORM_W-1:0] Q1 = pax_pkg::NORM_W'(pax_pkg::QUARTER_STEPS);
  localparam logic [pax_pkg::NORM_W-1:0] Q2 = pax_pkg::NORM_W'(2 * pax_pkg::QUARTER_STEPS);
  localparam logic [pax_pkg::NORM_W-1:0] Q3 = pax_pkg::NORM_W'(3 * pax_pkg::QUARTER_STEPS);
  localparam logic [pax_pkg::REM_W-1:0]  QR = pax_pkg::REM_W'(pax_pkg::QUARTER_STEPS);

  // Interpolated sine over one quarter, r in steps of 1/128 degree
  function automatic logic [pax_pkg::SIN_W-1:0] quarter_sin(
    input logic [pax_pkg::REM_W-1:0] r
  );
    logic [pax_pkg::TBL_IDX_W-1:0] idx;
    logic [pax_pkg::TBL_IDX_W-1:0] idx_hi;
    logic [pax_pkg::DEG_BITS-1:0]  frac;
    logic [pax_pkg::SIN_W-1:0]     lo;
    logic [pax_pkg::SIN_W-1:0]     hi;
    logic [MUL_W-1:0]              prod;
    idx    = r[pax_pkg::REM_W-1:pax_pkg::DEG_BITS];
    frac   = r[pax_pkg::DEG_BITS-1:0];
    idx_hi = (idx < pax_pkg::TBL_IDX_W'(pax_pkg::TBL_LAST)) ?
             idx + pax_pkg::TBL_IDX_W'(1) : pax_pkg::TBL_IDX_W'(pax_pkg::TBL_LAST);
    lo     = pax_pkg::SIN_W'(pax_pkg::SIN_TBL[idx]);
    hi     = pax_pkg::SIN_W'(pax_pkg::SIN_TBL[idx_hi]);
    prod   = MUL_W'(hi - lo) * MUL_W'(frac) + MUL_W'(pax_pkg::STEPS_PER_DEG / 2);
    return lo + pax_pkg::SIN_W'(prod >> pax_pkg::DEG_BITS);
  endfunction

  // Q1.16 to the working fraction width, rounding half up when narrowing
  function automatic logic signed [pax_pkg::TRIG_W-1:0] to_trig(input logic signed [17:0] v);
    logic signed [EXT_W-1:0] w;
    logic signed [EXT_W-1:0] rnd;
    w   = EXT_W'(v);
    rnd = '0;
    rnd[DN_SH-1] = 1'b1;
    if (pax_pkg::TRIG_FRAC_BITS >= 16) begin
      w = w <<< UP_SH;
    end else begin
      w = w + rnd;
      w = w >>> DN_SH;
    end
    return w[pax_pkg::TRIG_W-1:0];
  endfunction

  logic [2:0]                      step;
  logic [pax_pkg::NORM_W-1:0]      norm;
  logic [pax_pkg::NORM_W-1:0]      norm_next;
  pax_pkg::quad_t                  quad_a;
  pax_pkg::quad_t                  quad_a_next;
  logic [pax_pkg::REM_W-1:0]       rem;
  logic [pax_pkg::REM_W-1:0]       rem_next;
  pax_pkg::quad_t                  quad_b;
  logic [pax_pkg::SIN_W-1:0]       sr;
  logic [pax_pkg::SIN_W-1:0]       cr;
  logic signed [17:0]              s_q16;
  logic signed [17:0]              c_q16;
  logic signed [17:0]              ang_ext;
  logic signed [17:0]              ang_red;

  assign busy = |step;

  // reduce angle into [0, 360) degrees
  always_comb begin
    ang_ext = 18'(load_angle);
    priority if (ang_ext < -FULL_S) begin
      ang_red = ang_ext + FULL2_S;
    end else if (ang_ext < 18'sd0) begin
      ang_red = ang_ext + FULL_S;
    end else if (ang_ext >= FULL_S) begin
      ang_red = ang_ext - FULL_S;
    end else begin
      ang_red = ang_ext;
    end
    norm_next = ang_red[pax_pkg::NORM_W-1:0];
  end

  // split into quadrant and remainder
  always_comb begin
    priority if (norm >= Q3) begin
      quad_a_next = pax_pkg::QUAD_IV;
      rem_next    = pax_pkg::REM_W'(norm - Q3);
    end else if (norm >= Q2) begin
      quad_a_next = pax_pkg::QUAD_III;
      rem_next    = pax_pkg::REM_W'(norm - Q2);
    end else if (norm >= Q1) begin
      quad_a_next = pax_pkg::QUAD_II;
      rem_next    = pax_pkg::REM_W'(norm - Q1);
    end else begin
      quad_a_next = pax_pkg::QUAD_I;
      rem_next    = pax_pkg::REM_W'(norm);
    end
  end

  // quadrant fold
  always_comb begin
    unique case (quad_b)
      pax_pkg::QUAD_I: begin
        s_q16 = $signed({1'b0, sr});
        c_q16 = $signed({1'b0, cr});
      end
      pax_pkg::QUAD_II: begin
        s_q16 = $signed({1'b0, cr});
        c_q16 = -$signed({1'b0, sr});
      end
      pax_pkg::QUAD_III: begin
        s_q16 = -$signed({1'b0, sr});
        c_q16 = -$signed({1'b0, cr});
      end
      pax_pkg::QUAD_IV: begin
        s_q16 = -$signed({1'b0, cr});
        c_q16 = $signed({1'b0, sr});
      end
      default: begin
        s_q16 = '0;
        c_q16 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      trig.cosine <= pax_pkg::TRIG_ONE;
      trig.sine   <= '0;
    end else begin
      step <= {step[1:0], load};
      if (step[2]) begin
        trig.sine   <= to_trig(s_q16);
        trig.cosine <= to_trig(c_q16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      norm <= norm_next;
    end
    if (step[0]) begin
      quad_a <= quad_a_next;
      rem    <= rem_next;
    end
    if (step[1]) begin
      quad_b <= quad_a;
      sr     <= quarter_sin(rem);
      cr     <= quarter_sin(QR - rem);
    end
  end

endmodule

// ===== src/pax_datapath.sv =====
// Three-stage point pipeline: input register, products, round and saturate.
module pax_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pax_pkg::trig_t                trig,
  input  pax_pkg::axis_t                axis,
  input  logic                          hold,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pax_pkg::DATA_W-1:0]    in_data,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pax_pkg::DATA_W-1:0]    out_data,
  output logic                          out_last
);

  localparam int CW    = pax_pkg::COORD_WIDTH;
  localparam int SUM_W = pax_pkg::PROD_W + 1;
  localparam int SH_W  = SUM_W - pax_pkg::TRIG_FRAC_BITS;
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // round half up, then clamp to the coordinate range
  function automatic logic signed [CW-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] rnd_v;
    logic signed [SUM_W-1:0] half;
    logic signed [SH_W-1:0]  sh;
    logic [SH_W-CW:0]        top;
    half  = '0;
    half[pax_pkg::TRIG_FRAC_BITS-1] = 1'b1;
    rnd_v = v + half;
    rnd_v = rnd_v >>> pax_pkg::TRIG_FRAC_BITS;
    sh    = rnd_v[SH_W-1:0];
    top   = sh[SH_W-1:CW-1];
    if ((&top) || !(|top)) begin
      return sh[CW-1:0];
    end else if (top[SH_W-CW]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  // stage 1: input register
  logic                             v1;
  logic signed [CW-1:0]             x1;
  logic signed [CW-1:0]             y1;
  logic signed [CW-1:0]             z1;
  logic                             last1;

  // stage 2: products
  logic                             v2;
  logic signed [pax_pkg::PROD_W-1:0] pc;
  logic signed [pax_pkg::PROD_W-1:0] qs;
  logic signed [pax_pkg::PROD_W-1:0] ps;
  logic signed [pax_pkg::PROD_W-1:0] qc;
  logic signed [CW-1:0]             o2;
  pax_pkg::axis_t                   axis2;
  logic                             last2;

  // stage 3: result register
  logic                             v3;
  logic signed [CW-1:0]             x3;
  logic signed [CW-1:0]             y3;
  logic signed [CW-1:0]             z3;
  logic                             last3;

  logic ready1;
  logic ready2;
  logic ready3;
  logic accept;

  logic signed [CW-1:0]             p_sel;
  logic signed [CW-1:0]             q_sel;
  logic signed [CW-1:0]             o_sel;
  logic signed [pax_pkg::TRIG_W-1:0] c_sel;
  logic signed [pax_pkg::TRIG_W-1:0] s_sel;

  logic signed [CW-1:0]             pn;
  logic signed [CW-1:0]             qn;
  logic signed [CW-1:0]             x3_next;
  logic signed [CW-1:0]             y3_next;
  logic signed [CW-1:0]             z3_next;

  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1 && !hold;
  assign accept   = in_valid && in_ready;

  // pick the rotated pair (p, q) and the untouched coordinate o
  always_comb begin
    c_sel = trig.cosine;
    s_sel = trig.sine;
    unique case (axis)
      pax_pkg::AXIS_Z: begin
        p_sel = x1;
        q_sel = y1;
        o_sel = z1;
      end
      pax_pkg::AXIS_Y: begin
        p_sel = z1;
        q_sel = x1;
        o_sel = y1;
      end
      pax_pkg::AXIS_X: begin
        p_sel = y1;
        q_sel = z1;
        o_sel = x1;
      end
      default: begin
        // no axis: unit rotation leaves the point as is
        p_sel = x1;
        q_sel = y1;
        o_sel = z1;
        c_sel = pax_pkg::TRIG_ONE;
        s_sel = '0;
      end
    endcase
  end

  // p' = p c - q s, q' = p s + q c
  always_comb begin
    pn = round_sat(SUM_W'(pc) - SUM_W'(qs));
    qn = round_sat(SUM_W'(ps) + SUM_W'(qc));
    unique case (axis2)
      pax_pkg::AXIS_Y: begin
        z3_next = pn;
        x3_next = qn;
        y3_next = o2;
      end
      pax_pkg::AXIS_X: begin
        y3_next = pn;
        z3_next = qn;
        x3_next = o2;
      end
      default: begin
        x3_next = pn;
        y3_next = qn;
        z3_next = o2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= accept;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1    <= in_data[CW-1:0];
      y1    <= in_data[2*CW-1:CW];
      z1    <= in_data[3*CW-1:2*CW];
      last1 <= in_last;
    end
    if (v1 && ready2) begin
      pc    <= p_sel * c_sel;
      qs    <= q_sel * s_sel;
      ps    <= p_sel * s_sel;
      qc    <= q_sel * c_sel;
      o2    <= o_sel;
      axis2 <= axis;
      last2 <= last1;
    end
    if (v2 && ready3) begin
      x3    <= x3_next;
      y3    <= y3_next;
      z3    <= z3_next;
      last3 <= last2;
    end
  end

  assign out_valid = v3;
  assign out_data  = {z3, y3, x3};
  assign out_last  = last3;

endmodule

// ===== src/point_axis_rotator.sv =====
// Top level of the point rotator: APB registers, sine/cosine setup, point pipeline.
//
// Rotates a stream of 3D points (signed Q19.12) about the z, y or x axis by
// the angle in rotation_angle (1/128 degree, any 17-bit value, taken modulo
// 360 degrees). Throughput is one word per cycle unless the output stalls or
// a register write or angle setup holds the input. An accepted word reaches
// m_tvalid through the input, product and result registers; the four 32x18
// multipliers sit in the middle stage. Each rotated coordinate is rounded to
// nearest (ties up) and saturated. axis_select code 3 passes points unchanged.
// Writing rotation_angle starts a sine/cosine derivation from a 91-entry
// quarter-wave table with linear interpolation; s_tready is held low in the
// write cycle and while the derivation runs. Registers: axis_select at byte 0,
// rotation_angle at byte 4 (decoded on paddr[2]); reads return the current
// value, with the angle sign extended. Reset gives the z axis and a zero angle.
module point_axis_rotator (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pax_pkg::TDATA_W-1:0]       s_tdata,   // in_x, in_y, in_z
  input  logic                              s_tlast,   // last_point
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pax_pkg::TDATA_W-1:0]       m_tdata,   // out_x, out_y, out_z
  output logic                              m_tlast,   // out_last
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pax_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pax_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pax_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  pax_pkg::axis_t                         axis;
  logic signed [pax_pkg::ANGLE_W-1:0]     angle;
  logic                                   cfg_wr;
  logic                                   angle_wr;
  pax_pkg::trig_t                         trig;
  logic                                   trig_busy;
  logic [pax_pkg::DATA_W-1:0]             dp_out;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign angle_wr = cfg_wr && (paddr[2] == pax_pkg::REG_ANGLE);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      axis  <= pax_pkg::AXIS_Z;
      angle <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pax_pkg::REG_AXIS:  axis  <= pax_pkg::axis_t'(pwdata[1:0]);
        pax_pkg::REG_ANGLE: angle <= pwdata[pax_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pax_pkg::REG_AXIS:  prdata = pax_pkg::APB_DATA_W'(axis);
      pax_pkg::REG_ANGLE: prdata = pax_pkg::APB_DATA_W'(angle);
      default:            prdata = '0;
    endcase
  end

  // sine/cosine are rebuilt from the written value, not from angle
  pax_trig u_trig (
    .clk        (clk),
    .rst        (rst),
    .load       (angle_wr),
    .load_angle (pwdata[pax_pkg::ANGLE_W-1:0]),
    .trig       (trig),
    .busy       (trig_busy)
  );

  // hold off new points during register writes and while the trig values are being rebuilt
  pax_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .trig      (trig),
    .axis      (axis),
    .hold      (trig_busy || cfg_wr),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata[pax_pkg::DATA_W-1:0]),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (dp_out),
    .out_last  (m_tlast)
  );

  assign m_tdata = pax_pkg::TDATA_W'(dp_out);

endmodule

// ===== src/pax_checker.sv =====
// Port-level checks for the point rotator, bound to the top level.
`include "assert_macros.svh"

module pax_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [pax_pkg::TDATA_W-1:0]       m_tdata,
  input logic                              m_tlast,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [pax_pkg::APB_ADDR_W-1:0]    paddr,
  input logic [pax_pkg::APB_DATA_W-1:0]    pwdata,
  input logic [pax_pkg::APB_DATA_W-1:0]    prdata
);

  // a stalled output word keeps its payload
  `PAX_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "output word changed under stall")

  // pipeline is empty right after reset
  `PAX_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

  // angle write holds s_tready low as the sine/cosine rebuild begins
  `PAX_ASSERT(a_angle_stall, (psel && penable && pwrite && (paddr[2] == pax_pkg::REG_ANGLE)) |-> (!s_tready ##1 !s_tready), "input taken during angle setup")

  // axis register reads back what was written
  `PAX_ASSERT(a_axis_readback, (psel && penable && pwrite && (paddr[2] == pax_pkg::REG_AXIS)) ##1 (psel && !pwrite && (paddr[2] == pax_pkg::REG_AXIS)) |-> (prdata[1:0] == $past(pwdata[1:0])), "axis readback mismatch")

endmodule

bind point_axis_rotator pax_checker u_pax_checker (.*);
